// ===== rtl/assert_macros.svh =====
// Assertion helpers for the consensus mean block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal is never unknown outside reset.
`define ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
    else $error(msg);

`endif

// ===== rtl/pcm_pkg.sv =====
package pcm_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     valid;
    logic                     last;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] mean_x;
    logic signed [CoordW-1:0] mean_y;
    logic [CountW-1:0]        count;
    logic                     ok;
  } result_t;

endpackage

// ===== rtl/pcm_fifo.sv =====
module pcm_fifo import pcm_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  point_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output point_t out_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  point_t          mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != (AW+1)'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

// ===== rtl/pcm_div.sv =====
// Signed sum divided by a small count, restoring, one quotient bit a cycle.
module pcm_div #(
  parameter int unsigned SumW = 22,
  parameter int unsigned DivW = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] num_i,
  input  logic [DivW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [SumW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(SumW+1);

  logic [SumW-1:0] q_q, mag;
  logic [DivW:0]   r_q, r_sh;
  logic [DivW-1:0] d_q;
  logic            neg_q, busy_q;
  logic [CW-1:0]   n_q;

  assign mag  = num_i[SumW-1] ? SumW'(-num_i) : SumW'(num_i);
  assign r_sh = {r_q[DivW-1:0], q_q[SumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0; n_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; n_q <= CW'(SumW);
      end else if (busy_q) begin
        n_q <= n_q - 1'b1;
        if (n_q == CW'(1)) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= mag; r_q <= '0; d_q <= den_i; neg_q <= num_i[SumW-1];
    end else if (busy_q) begin
      if (r_sh >= {1'b0, d_q}) begin
        r_q <= r_sh - {1'b0, d_q};
        q_q <= {q_q[SumW-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[SumW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

// ===== rtl/pcm_engine.sv =====
module pcm_engine import pcm_pkg::*; #(
  parameter int unsigned MaxPoints = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] thr_i,
  input  logic        pt_valid_i,
  output logic        pt_ready_o,
  input  point_t      pt_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);
`include "assert_macros.svh"
  localparam int unsigned IW   = $clog2(MaxPoints);
  localparam int unsigned NW   = $clog2(MaxPoints+1);
  localparam int unsigned SumW = CoordW + NW + 1;
  localparam int unsigned DW   = CoordW + 3;
  localparam int unsigned D2W  = 2 * DW;

  localparam logic [2:0] S_LOAD = 3'd0, S_PAIR = 3'd1, S_SCAN = 3'd2,
                         S_EVAL = 3'd3, S_DIV  = 3'd4, S_OUT  = 3'd5;

  // Store entry: {x, y, valid}.
  logic [2*CoordW:0]        mem_q [MaxPoints];
  logic [2*CoordW:0]        rd_q;
  logic [IW-1:0]            raddr;

  logic [2:0]               st_q, st_d;
  logic [NW-1:0]            n_q, n_d, cnt_q, cnt_d, best_q, best_d, k_q, k_d;
  logic [IW-1:0]            i_q, i_d, j_q, j_d;
  logic [1:0]               ph_q, ph_d;
  logic signed [CoordW:0]   sx_q, sx_d, sy_q, sy_d;
  logic signed [SumW-1:0]   accx_q, accx_d, accy_q, accy_d, bx_q, bx_d, by_q, by_d;
  logic                     pv_q, pv_d, small_q, small_d, divx_q, divx_d;
  logic                     dstart_q, dstart_d, rv_q, rv_d;
  logic signed [CoordW-1:0] mx_q, mx_d;
  result_t                  res_q, res_d;

  logic signed [CoordW-1:0] px, py;
  logic                     pval;
  logic signed [DW-1:0]     dx, dy;
  logic [D2W-1:0]           sqx, sqy, d2, lim;
  logic                     inl, ddone, pt_acc, store_ok, last_pair;
  logic [NW-1:0]            n_new, n_last;
  logic signed [SumW-1:0]   dnum, dquo;

  assign px   = rd_q[2*CoordW:CoordW+1];
  assign py   = rd_q[CoordW:1];
  assign pval = rd_q[0];

  // Doubled offset from the pair midpoint, compared at four times the radius.
  assign dx  = (DW'(px) <<< 1) - DW'(sx_q);
  assign dy  = (DW'(py) <<< 1) - DW'(sy_q);
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign d2  = sqx + sqy;
  assign lim = D2W'({thr_i, 2'b00});
  assign inl = pval && (d2 < lim);

  assign pt_ready_o  = (st_q == S_LOAD);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  assign pt_acc    = pt_valid_i && pt_ready_o;
  assign store_ok  = (n_q < NW'(MaxPoints));
  assign n_new     = store_ok ? n_q + 1'b1 : n_q;
  assign n_last    = n_q - 1'b1;
  assign last_pair = (NW'(i_q) == n_last) && (NW'(j_q) == n_last);

  assign raddr = (st_q != S_PAIR) ? k_q[IW-1:0] : ((ph_q == 2'd0) ? i_q : j_q);

  always_ff @(posedge clk_i) begin
    if (pt_acc && store_ok) begin
      mem_q[n_q[IW-1:0]] <= {pt_i.x, pt_i.y, pt_i.valid};
    end
    rd_q <= mem_q[raddr];
  end

  assign dnum = divx_q ? bx_q : by_q;

  pcm_div #(.SumW(SumW), .DivW(NW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart_q), .num_i(dnum), .den_i(best_q),
    .done_o(ddone), .quo_o(dquo)
  );

  always_comb begin
    st_d     = st_q;     n_d      = n_q;      cnt_d   = cnt_q;   best_d  = best_q;
    k_d      = k_q;      i_d      = i_q;      j_d     = j_q;     ph_d    = ph_q;
    sx_d     = sx_q;     sy_d     = sy_q;     accx_d  = accx_q;  accy_d  = accy_q;
    bx_d     = bx_q;     by_d     = by_q;     pv_d    = pv_q;    small_d = small_q;
    divx_d   = divx_q;   dstart_d = 1'b0;     mx_d    = mx_q;    res_d   = res_q;
    rv_d     = rv_q && !res_ready_i;
    unique case (st_q)
      S_LOAD: begin
        if (pt_valid_i) begin
          n_d = n_new;
          if (pt_i.last) begin
            best_d = '0; bx_d = '0; by_d = '0; i_d = '0; j_d = '0; k_d = '0;
            ph_d = '0; cnt_d = '0; accx_d = '0; accy_d = '0; sx_d = '0; sy_d = '0;
            small_d = (n_new <= NW'(2));
            st_d = (n_new <= NW'(2)) ? S_SCAN : S_PAIR;
          end
        end
      end
      S_PAIR: begin
        // Fetch p_i then p_j; build the doubled midpoint.
        unique case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            ph_d = 2'd2;
            sx_d = (CoordW+1)'(px);
            sy_d = (CoordW+1)'(py);
            pv_d = pval;
          end
          2'd2: begin
            sx_d = sx_q + (CoordW+1)'(px);
            sy_d = sy_q + (CoordW+1)'(py);
            pv_d = pv_q && pval;
            ph_d = '0; k_d = '0; cnt_d = '0; accx_d = '0; accy_d = '0;
            st_d = (pv_q && pval) ? S_SCAN : S_EVAL;
          end
          default: ph_d = '0;
        endcase
      end
      S_SCAN: begin
        // k_q addresses the store; the data of k-1 is on rd_q.
        ph_d = 2'd1;
        if (k_q != n_q) k_d = k_q + 1'b1;
        if (ph_q == 2'd1) begin
          if (small_q ? pval : inl) begin
            cnt_d  = cnt_q + 1'b1;
            accx_d = accx_q + SumW'(px);
            accy_d = accy_q + SumW'(py);
          end
          if (k_q == n_q) begin
            st_d = S_EVAL;
            ph_d = '0;
          end
        end
      end
      S_EVAL: begin
        if (small_q || (pv_q && cnt_q > best_q)) begin
          best_d = cnt_q; bx_d = accx_q; by_d = accy_q;
        end
        if (small_q || (pv_q && cnt_q > best_q && cnt_q >= n_q) || last_pair) begin
          st_d = S_DIV; divx_d = 1'b1; dstart_d = 1'b1;
        end else begin
          st_d = S_PAIR; ph_d = '0;
          if (NW'(j_q) == n_last) begin
            i_d = i_q + 1'b1; j_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      S_DIV: begin
        if (ddone) begin
          if (divx_q) begin
            mx_d = dquo[CoordW-1:0]; divx_d = 1'b0; dstart_d = 1'b1;
          end else begin
            st_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        // Hold until the output register is free or being drained.
        if (!rv_q || res_ready_i) begin
          res_d.mean_x = (best_q == '0) ? '0 : mx_q;
          res_d.mean_y = (best_q == '0) ? '0 : dquo[CoordW-1:0];
          res_d.count  = CountW'(best_q);
          res_d.ok     = (best_q != '0);
          rv_d = 1'b1;
          st_d = S_LOAD;
          n_d  = '0;
        end
      end
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; n_q <= '0; cnt_q <= '0; best_q <= '0; k_q <= '0;
      i_q <= '0; j_q <= '0; ph_q <= '0; sx_q <= '0; sy_q <= '0;
      accx_q <= '0; accy_q <= '0; bx_q <= '0; by_q <= '0; pv_q <= 1'b0;
      small_q <= 1'b0; divx_q <= 1'b0; dstart_q <= 1'b0; mx_q <= '0;
      res_q <= '0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d; n_q <= n_d; cnt_q <= cnt_d; best_q <= best_d; k_q <= k_d;
      i_q <= i_d; j_q <= j_d; ph_q <= ph_d; sx_q <= sx_d; sy_q <= sy_d;
      accx_q <= accx_d; accy_q <= accy_d; bx_q <= bx_d; by_q <= by_d; pv_q <= pv_d;
      small_q <= small_d; divx_q <= divx_d; dstart_q <= dstart_d; mx_q <= mx_d;
      res_q <= res_d; rv_q <= rv_d;
    end
  end

  `ASSERT_CLK(a_out_nonzero, clk_i, rst_ni, res_valid_o && res_o.ok |-> res_o.count != '0,
              "valid result with zero count")
  `ASSERT_CLK(a_start_div, clk_i, rst_ni, dstart_q |-> st_q == S_DIV,
              "division started outside the division state")
  `ASSERT_CLK(a_count_cap, clk_i, rst_ni, n_q <= NW'(MaxPoints),
              "point count beyond store depth")
endmodule

// ===== rtl/pairwise_consensus_mean_2d.sv =====
// Pairwise consensus mean of 2D points. Points stream in one per item on s_axis; the item with
// tlast closes the set, and points beyond the MAX_POINTS store are dropped. The block then tries
// every pair i<=j of stored points, takes twice the midpoint, counts points within the threshold
// radius one point per cycle on a single store read port, keeps the first strictly larger
// inlier set and stops once all points are inliers. Sets of at most two points give the plain
// mean of the valid points. The result item comes out on m_axis; result_valid is 0 when nothing
// was found. A closed set of N > 2 points is then searched over N(N+1)/2 pairs, with a store
// scan only for a pair of two valid points, up to the pair whose set holds every point. Two
// serial divisions, x then y, follow before the output register is loaded. The result waits in
// the output register while the next set loads, and two points wait in the input queue while a
// set is searched. Write the radius register only while the block is idle.
module pairwise_consensus_mean_2d import pcm_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // point_x[15:0], point_y[31:16], point_valid[32]
  input  logic        s_axis_tlast,  // last_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mean_x[15:0], mean_y[31:16], inlier_count[36:32], result_valid[37]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  logic [31:0] thr_q;
  point_t      in_pt, q_pt;
  logic        q_valid, q_ready;
  result_t     res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= 32'h0001_0000;
    else if (cfg_valid_i) thr_q <= cfg_data_i;
  end

  assign in_pt = '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
                   valid: s_axis_tdata[32], last: s_axis_tlast};

  pcm_fifo #(.Depth(2)) u_fifo (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(in_pt), .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_pt)
  );

  pcm_engine #(.MaxPoints(MAX_POINTS)) u_engine (
    .clk_i, .rst_ni, .thr_i(thr_q), .pt_valid_i(q_valid), .pt_ready_o(q_ready),
    .pt_i(q_pt), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {2'b00, res.ok, res.count, res.mean_y, res.mean_x};
endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPts = 16;
  localparam int unsigned RandSets = 118;
  localparam longint unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainCycles = 2000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               valid;
  } pt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  pairwise_consensus_mean_2d dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: the point set being loaded and the radius register.
  pt_t             set_pts[MaxPts];
  int unsigned     set_len;
  logic [31:0]     radius_sq;
  logic [37:0]     mean_q[$];

  int unsigned     n_mismatch;
  int unsigned     n_results;
  int unsigned     n_items;
  longint unsigned cycle_cnt;
  bit              stall_rx;

  // Build the expected result word {ok, count, mean_y, mean_x} from a sum and a count.
  function automatic logic [37:0] pack_mean(longint sx, longint sy, int unsigned cnt);
    longint mx, my;
    logic [4:0] c;
    if (cnt == 0) return '0;
    mx = sx / longint'(cnt);
    my = sy / longint'(cnt);
    c = cnt[4:0];
    return {1'b1, c, my[15:0], mx[15:0]};
  endfunction

  // Pair search, stopping once all points are inliers; up to two points give the mean.
  function automatic logic [37:0] consensus_mean();
    int unsigned n, best, cnt;
    longint bsx, bsy, sx, sy, s2x, s2y, dx, dy;
    longint unsigned lim, d2;
    n = set_len;
    best = 0; bsx = 0; bsy = 0;
    if (n <= 2) begin
      for (int k = 0; k < n; k++) begin
        if (set_pts[k].valid) begin
          bsx += set_pts[k].x;
          bsy += set_pts[k].y;
          best++;
        end
      end
      return pack_mean(bsx, bsy, best);
    end
    lim = longint'(radius_sq) * 4;
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        if (!set_pts[i].valid || !set_pts[j].valid) continue;
        s2x = longint'(set_pts[i].x) + set_pts[j].x;
        s2y = longint'(set_pts[i].y) + set_pts[j].y;
        cnt = 0; sx = 0; sy = 0;
        for (int k = 0; k < n; k++) begin
          if (!set_pts[k].valid) continue;
          dx = 2 * longint'(set_pts[k].x) - s2x;
          dy = 2 * longint'(set_pts[k].y) - s2y;
          d2 = longint'(dx * dx) + longint'(dy * dy);
          if (d2 < lim) begin
            cnt++;
            sx += set_pts[k].x;
            sy += set_pts[k].y;
          end
        end
        if (cnt > best) begin
          best = cnt; bsx = sx; bsy = sy;
          if (cnt >= n) return pack_mean(bsx, bsy, best);
        end
      end
    end
    return pack_mean(bsx, bsy, best);
  endfunction

  // Store a point (drop it once the set is full); close the set on the last point.
  function automatic void predict_point(pt_t p, logic last);
    if (set_len < MaxPts) begin
      set_pts[set_len] = p;
      set_len++;
    end
    if (last) begin
      mean_q = {mean_q, consensus_mean()};
      set_len = 0;
    end
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one point item; wait for acceptance, then idle a random gap unless no_gap.
  task automatic send_point(pt_t p, logic last, bit no_gap = 0);
    int unsigned g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, p.valid, p.y, p.x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_point(p, last);
    n_items++;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
  endtask

  // Wait until every expected result has arrived, plus the block's tail latency.
  task automatic wait_drained();
    idle_sender();
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [31:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radius_sq = v;
  endtask

  function automatic pt_t mk(int x, int y, bit v = 1);
    pt_t p;
    p.x = x[15:0]; p.y = y[15:0]; p.valid = v;
    return p;
  endfunction

  function automatic pt_t rand_pt(int cx, int cy, int spread, int pct_valid);
    int x, y;
    x = cx + $urandom_range(0, 2 * spread) - spread;
    y = cy + $urandom_range(0, 2 * spread) - spread;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return mk(x, y, $urandom_range(0, 99) < pct_valid);
  endfunction

  // Small sets: empty fallback, one and two points, invalid mix, coordinate extremes.
  task automatic test_small_sets();
    send_point(mk(0, 0, 0), 1'b1);
    send_point(mk(-32768, 32767), 1'b1);
    send_point(mk(32767, -32768), 1'b0);
    send_point(mk(32767, -32768), 1'b1);
    send_point(mk(-5, 7, 0), 1'b0);
    send_point(mk(-3, -1), 1'b1);
    send_point(mk(-32768, -32768), 1'b0);
    send_point(mk(-32767, -32768), 1'b1);
  endtask

  // Larger sets: outlier rejection, all invalid, nothing within a zero radius.
  task automatic test_consensus();
    send_point(mk(256, 256), 1'b0);
    send_point(mk(300, 200), 1'b0);
    send_point(mk(-9000, 12000), 1'b0);
    send_point(mk(280, 240), 1'b1);
    for (int k = 0; k < 3; k++) send_point(mk(k, k, 0), k == 2);
    write_radius(32'd0);
    for (int k = 0; k < 4; k++) send_point(mk(k * 3, -k), k == 3);
  endtask

  // Overfull set: points beyond the store depth are dropped, last one still closes it.
  task automatic test_overflow();
    write_radius(32'hFFFF_FFFF);
    for (int k = 0; k < MaxPts + 3; k++)
      send_point(mk(k * 1000 - 9000, 32767 - k * 3000), k == MaxPts + 2);
  endtask

  task automatic test_random_sets();
    int unsigned len, spread;
    int cx, cy;
    logic [31:0] rads[6];
    rads = '{32'd0, 32'd1, 32'd65536, 32'h0010_0000, 32'h4000_0000, 32'hFFFF_FFFF};
    for (int s = 0; s < RandSets; s++) begin
      if (s % 18 == 17) write_radius(rads[$urandom_range(0, 5)]);
      if (s % 18 == 8) write_radius($urandom());
      if (s == 40) wait_drained();
      // Mostly small sets keep the pair search short; a few fill the store.
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 7);
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      spread = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 600);
      for (int k = 0; k < len; k++)
        send_point(rand_pt(cx, cy, spread, ($urandom_range(0, 4) == 0) ? 40 : 92),
                   k == len - 1, $urandom_range(0, 4) == 0);
    end
    idle_sender();
  endtask

  // Result side: random back-pressure, compare each item with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (mean_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result item %h", m_axis_tdata[37:0]);
        end else begin
          logic [37:0] exp_w;
          exp_w = mean_q.pop_front();
          if (m_axis_tdata[37:0] !== exp_w) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d: exp ok=%0d cnt=%0d mx=%h my=%h, got ok=%0d cnt=%0d mx=%h my=%h",
                       n_results, exp_w[37], exp_w[36:32], exp_w[15:0], exp_w[31:16],
                       m_axis_tdata[37], m_axis_tdata[36:32], m_axis_tdata[15:0],
                       m_axis_tdata[31:16]);
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_rx <= ~stall_rx;
      m_axis_tready <= stall_rx ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 3) != 0);
    end
  end

  // Hard stop against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    set_len = 0; radius_sq = 32'd65536;
    n_mismatch = 0; n_results = 0; n_items = 0; cycle_cnt = 0; stall_rx = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_sets();
    test_consensus();
    test_overflow();
    write_radius(32'd65536);
    test_random_sets();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d point items and %0d results over small, full and overfull sets",
             n_items, n_results);
    $display("with radius extremes, invalid points and random stalls on both sides");
    if (n_mismatch == 0 && mean_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_mismatch, mean_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
